### design/cfe_pkg.sv
// cfe_pkg: shared types, constants and the hash step for the cuckoo filter engine
`timescale 1ns / 1ps

package cfe_pkg;

   localparam int BUCKET_COUNT = 128;
   localparam int IDX_W        = $clog2(BUCKET_COUNT);
   localparam int FP_W         = 16;
   localparam int LIMIT_W      = 7;

   localparam logic [FP_W-1:0]    HASH_SEED   = 16'd5381;
   localparam logic [LIMIT_W-1:0] RELOC_RESET = 7'd8;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef struct packed {
      op_type          operation;
      logic [FP_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic            success;
      logic [FP_W-1:0] lost_fingerprint;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KEY_HI,
      ST_FP_LO,
      ST_FP_HI,
      ST_RD1,
      ST_RD2,
      ST_CHK2,
      ST_VH_LO,
      ST_VH_HI,
      ST_VRD,
      ST_VWR,
      ST_DONE
   } state_type;

   // one byte of the djb hash: h * 33 + b, kept to 16 bits
   function automatic logic [FP_W-1:0] djb_step(input logic [FP_W-1:0] h,
                                                input logic [7:0] b);
      return (h << 5) + h + {8'd0, b};
   endfunction

endpackage

### design/cfe_hash.sv
// cfe_hash: shared two-step djb hash unit, one byte per cycle
`timescale 1ns / 1ps

module cfe_hash (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [cfe_pkg::FP_W-1:0] src,
   output logic [cfe_pkg::FP_W-1:0] hash
);
   import cfe_pkg::*;

   logic [FP_W-1:0] hval_ff, hval_in;
   logic [7:0]      hi_ff, hi_in;
   logic            step_ff, step_in;

   always_comb begin
      hval_in = hval_ff;
      hi_in   = hi_ff;
      step_in = 1'b0;
      if (start) begin
         hval_in = djb_step(HASH_SEED, src[7:0]);
         hi_in   = src[15:8];
         step_in = 1'b1;
      end else if (step_ff) begin
         hval_in = djb_step(hval_ff, hi_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      hval_ff <= hval_in;
      hi_ff   <= hi_in;
   end

   assign hash = hval_ff;

endmodule

### design/cuckoo_filter_engine_unit.sv
// cuckoo_filter_engine_unit: cuckoo filter top level with sequencer and fingerprint table
//
//   channel   dir   handshake            payload
//   req_      in    req_valid/req_stall  req_payload (operation, key)
//   rsp_      out   rsp_valid/rsp_stall  rsp_payload (success, lost_fingerprint)
//   csr_      in    csr_valid/csr_ready  csr_data (relocation_limit)
//
// lookup reads both buckets; insert writes bucket one if free, else bucket two, then
// relocates the displaced entry: two hash steps, one table read, one table write per move.
// clear and unused codes go straight to done. one table port, so one access per cycle.
// reset and clear empty the table at once through per-entry valid flops; no sweep.
// req_stall is high from accept until the result moves into the output register;
// a result waiting on rsp_stall does not block the next accept.
`timescale 1ns / 1ps

module cuckoo_filter_engine_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  cfe_pkg::req_type            req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output cfe_pkg::rsp_type            rsp_payload,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [cfe_pkg::LIMIT_W-1:0] csr_data
);
   import cfe_pkg::*;

   state_type state_ff, state_in;

   logic [LIMIT_W-1:0] limit_ff;
   op_type             op_ff, op_in;
   logic [FP_W-1:0]    fp_ff, fp_in;
   logic [IDX_W-1:0]   i1_ff, i1_in;
   logic [IDX_W-1:0]   i2_ff, i2_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [FP_W-1:0]    t1_ff, t1_in;
   logic [FP_W-1:0]    victim_ff, victim_in;
   logic [LIMIT_W-1:0] moves_ff, moves_in;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic               accept;
   logic               out_free;
   logic [LIMIT_W:0]   moves_next;

   // shared hash unit
   logic               hash_start;
   logic [FP_W-1:0]    hash_src;
   logic [FP_W-1:0]    hash;

   // table port
   logic [FP_W-1:0]    mem [BUCKET_COUNT];
   logic [BUCKET_COUNT-1:0] vld_ff;
   logic [FP_W-1:0]    rdata_ff;
   logic               rvld_ff;
   logic [FP_W-1:0]    rd_val;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [FP_W-1:0]    wr_data;
   logic               tbl_clr;

   cfe_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .src   (hash_src),
      .hash  (hash)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign csr_ready   = 1'b1;
   assign rd_val      = rvld_ff ? rdata_ff : '0;
   assign moves_next  = {1'b0, moves_ff} + 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_payload.operation == OP_INSERT || req_payload.operation == OP_LOOKUP)
                  state_in = ST_KEY_HI;
               else
                  state_in = ST_DONE;
            end
         end
         ST_KEY_HI: state_in = ST_FP_LO;
         ST_FP_LO:  state_in = ST_FP_HI;
         ST_FP_HI:  state_in = ST_RD1;
         ST_RD1:    state_in = ST_RD2;
         ST_RD2: begin
            if (op_ff == OP_INSERT && rd_val == '0)
               state_in = ST_DONE;
            else
               state_in = ST_CHK2;
         end
         ST_CHK2: begin
            if (op_ff == OP_INSERT && rd_val != '0)
               state_in = ST_VH_LO;
            else
               state_in = ST_DONE;
         end
         ST_VH_LO:  state_in = ST_VH_HI;
         ST_VH_HI:  state_in = ST_VRD;
         ST_VRD:    state_in = ST_VWR;
         ST_VWR: begin
            if (rd_val == '0 || moves_next >= {1'b0, limit_ff})
               state_in = ST_DONE;
            else
               state_in = ST_VH_LO;
         end
         ST_DONE: begin
            if (out_free)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      op_in      = op_ff;
      fp_in      = fp_ff;
      i1_in      = i1_ff;
      i2_in      = i2_ff;
      idx_in     = idx_ff;
      t1_in      = t1_ff;
      victim_in  = victim_ff;
      moves_in   = moves_ff;
      res_in     = res_ff;
      hash_start = 1'b0;
      hash_src   = victim_ff;
      rd_en      = 1'b0;
      rd_addr    = i1_ff;
      wr_en      = 1'b0;
      wr_addr    = i2_ff;
      wr_data    = fp_ff;
      tbl_clr    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in                   = req_payload.operation;
               res_in.success          = 1'b0;
               res_in.lost_fingerprint = '0;
               hash_src                = req_payload.key;
               if (req_payload.operation == OP_INSERT || req_payload.operation == OP_LOOKUP)
                  hash_start = 1'b1;
               else if (req_payload.operation == OP_CLEAR) begin
                  tbl_clr        = 1'b1;
                  res_in.success = 1'b1;
               end
            end
         end
         ST_FP_LO: begin
            // key hash is the fingerprint; now hash the fingerprint
            fp_in      = hash;
            i1_in      = hash[IDX_W-1:0];
            hash_start = 1'b1;
            hash_src   = hash;
         end
         ST_RD1: begin
            i2_in   = i1_ff ^ hash[IDX_W-1:0];
            rd_en   = 1'b1;
            rd_addr = i1_ff;
         end
         ST_RD2: begin
            t1_in   = rd_val;
            rd_addr = i2_ff;
            if (op_ff == OP_INSERT && rd_val == '0) begin
               wr_en          = 1'b1;
               wr_addr        = i1_ff;
               res_in.success = 1'b1;
            end else begin
               rd_en = 1'b1;
            end
         end
         ST_CHK2: begin
            if (op_ff == OP_LOOKUP) begin
               res_in.success = (t1_ff == fp_ff) || (rd_val == fp_ff);
            end else begin
               // bucket two takes the new fingerprint either way
               wr_en     = 1'b1;
               wr_addr   = i2_ff;
               victim_in = rd_val;
               idx_in    = i2_ff;
               moves_in  = '0;
               if (rd_val == '0)
                  res_in.success = 1'b1;
            end
         end
         ST_VH_LO: begin
            hash_start = 1'b1;
            hash_src   = victim_ff;
         end
         ST_VRD: begin
            idx_in  = idx_ff ^ hash[IDX_W-1:0];
            rd_en   = 1'b1;
            rd_addr = idx_ff ^ hash[IDX_W-1:0];
         end
         ST_VWR: begin
            wr_en     = 1'b1;
            wr_addr   = idx_ff;
            wr_data   = victim_ff;
            victim_in = rd_val;
            moves_in  = moves_next[LIMIT_W-1:0];
            res_in.success          = (rd_val == '0);
            res_in.lost_fingerprint = rd_val;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= RELOC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready)
            limit_ff <= csr_data;
         if (state_ff == ST_DONE && out_free)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      fp_ff     <= fp_in;
      i1_ff     <= i1_in;
      i2_ff     <= i2_in;
      idx_ff    <= idx_in;
      t1_ff     <= t1_in;
      victim_ff <= victim_in;
      moves_ff  <= moves_in;
      res_ff    <= res_in;
      if (state_ff == ST_DONE && out_free)
         rsp_ff <= res_ff;
   end

   // fingerprint table, one access per cycle
   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
         rvld_ff  <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || tbl_clr) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

`ifndef ASSERT_OFF
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid && rsp_stall) |=> state_ff == ST_DONE)
      else $error("result register overwritten while a beat waits");

   a_moves_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VH_LO && moves_ff != '0) |-> moves_ff < limit_ff)
      else $error("relocation ran past the limit");

   a_hash_start: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.operation == OP_INSERT) |=> state_ff == ST_KEY_HI)
      else $error("insert beat did not start the hash");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en && rd_addr == wr_addr))
      else $error("table read and write to the same entry in one cycle");
`endif

endmodule
